// ===== rtl/min_heap_job_dispatcher_defines.svh =====
// ----------------------------------------------------------------------------
// min_heap_job_dispatcher_defines
// Assertion macros used by the checker file mhjd_checker.sv.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_JOB_DISPATCHER_DEFINES_SVH
`define MIN_HEAP_JOB_DISPATCHER_DEFINES_SVH

// Clocked assertion, masked while reset is active.
`define MHJD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MHJD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mhjd_pkg.sv =====
// ----------------------------------------------------------------------------
// mhjd_pkg
// Types, widths and the heap ordering function of the job dispatcher.
// ----------------------------------------------------------------------------
package mhjd_pkg;

  localparam int unsigned TimeBits = 16;
  localparam int unsigned IdBits   = 10;

  localparam logic ModeArrival = 1'b0;
  localparam logic ModeTick    = 1'b1;
  localparam logic KindDispatch = 1'b0;
  localparam logic KindDrop     = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [IdBits-1:0]   job_id;
    logic [TimeBits-1:0] start_time;
    logic [TimeBits-1:0] end_time;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [IdBits-1:0]   out_job;
    logic [TimeBits-1:0] out_start;
    logic [TimeBits-1:0] dispatch_time;
    logic [TimeBits-1:0] finish_time;
    logic [TimeBits-1:0] wait_time;
  } out_item_t;

  // Heap entry, the key ordering is end, then start, then id.
  typedef struct packed {
    logic [TimeBits-1:0] end_time;
    logic [TimeBits-1:0] start_time;
    logic [IdBits-1:0]   job_id;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } heap_req_t;

  typedef struct packed {
    logic   busy;
    logic   full;
    logic   empty;
    logic   root_valid;
    entry_t root;
  } heap_rsp_t;

  // Packed compare of the concatenated key gives the three-level tie break.
  function automatic logic entry_before(entry_t a, entry_t b);
    logic res;
    res = (a < b);
    return res;
  endfunction

endpackage

// ===== rtl/min_heap_job_dispatcher.sv =====
// ----------------------------------------------------------------------------
// min_heap_job_dispatcher
// Non-preemptive earliest-deadline-first dispatcher over a RAM-based min-heap.
// ----------------------------------------------------------------------------
//  channel | signals                        | payload
//  in      | in_valid_i / in_ready_o        | in_data_i  (mode, job, start, end)
//  out     | out_valid_o / out_ready_i      | out_data_o (kind, job, times)
//
//  Arrival: written straight to the root when empty, else it climbs the heap
//  level by level (S_UP, S_WR); a drop goes straight to the result register.
//  Tick: advances time; a dispatch reads the root (S_ROOT), then, unless the heap empties, the
//  last entry (S_LAST), then descends via S_CHK, S_LEFT, S_RIGHT, S_CMP, paced by the single RAM read port.
//  Reset clears count, time and busy state; the heap RAM is not cleared.
//  One result can wait behind a stalled output; a second one holds off input.
module min_heap_job_dispatcher #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mhjd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mhjd_pkg::out_item_t out_data_o
);
  import mhjd_pkg::*;

  heap_req_t req;
  heap_rsp_t rsp;

  logic [TimeBits-1:0] now_q, now_d, busy_until_q;
  logic                busy_q, pend_q, out_valid_q;
  out_item_t           res_q, out_q;
  logic                in_acc, drop_acc, out_free, proc_free;
  logic [TimeBits-1:0] dur, fin;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !rsp.busy && !pend_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign drop_acc   = in_acc && (in_data_i.mode == ModeArrival) && rsp.full;

  assign now_d     = now_q + TimeBits'(1);
  assign proc_free = !busy_q || (now_d == busy_until_q);

  assign req.push  = in_acc && (in_data_i.mode == ModeArrival) && !rsp.full;
  assign req.pop   = in_acc && (in_data_i.mode == ModeTick) && proc_free && !rsp.empty;
  assign req.entry = '{end_time: in_data_i.end_time, start_time: in_data_i.start_time,
                       job_id: in_data_i.job_id};

  assign dur = rsp.root.end_time - rsp.root.start_time;
  assign fin = now_q + dur;

  mhjd_heap #(
    .DEPTH(QUEUE_DEPTH)
  ) u_heap (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      busy_until_q <= '0;
      busy_q       <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc && (in_data_i.mode == ModeTick)) begin
        now_q <= now_d;
        if (busy_q && (now_d == busy_until_q)) begin
          busy_q <= 1'b0;
        end
      end
      if (rsp.root_valid) begin
        busy_until_q <= fin;
        busy_q       <= (dur != '0);
      end
      // res_q holds one result until the output register frees up
      if (rsp.root_valid || drop_acc) begin
        pend_q <= 1'b1;
      end else if (pend_q && out_free) begin
        pend_q <= 1'b0;
      end
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.root_valid) begin
      res_q <= '{kind: KindDispatch, out_job: rsp.root.job_id,
                 out_start: rsp.root.start_time, dispatch_time: now_q,
                 finish_time: fin, wait_time: now_q - rsp.root.start_time};
    end else if (drop_acc) begin
      res_q <= '{kind: KindDrop, out_job: in_data_i.job_id,
                 out_start: in_data_i.start_time, dispatch_time: '0,
                 finish_time: '0, wait_time: '0};
    end
    if (pend_q && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/mhjd_ram.sv =====
// ----------------------------------------------------------------------------
// mhjd_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mhjd_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mhjd_heap.sv =====
// ----------------------------------------------------------------------------
// mhjd_heap
// Binary min-heap sequencer: hole-based sift up on push, sift down on pop.
// ----------------------------------------------------------------------------
module mhjd_heap #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mhjd_pkg::heap_req_t req_i,
  output mhjd_pkg::heap_rsp_t rsp_o
);
  import mhjd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = AW + 2;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_UP    = 9'b000000010,
    S_WR    = 9'b000000100,
    S_ROOT  = 9'b000001000,
    S_LAST  = 9'b000010000,
    S_CHK   = 9'b000100000,
    S_LEFT  = 9'b001000000,
    S_RIGHT = 9'b010000000,
    S_CMP   = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic [AW-1:0]   bidx_q, bidx_d;
  entry_t          item_q, item_d;
  entry_t          best_q, best_d;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata;
  logic [EntryBits-1:0] rdata_raw;

  logic [AW-1:0]   cnt_pos, cnt_m1, bidx_m1;
  logic [LW-1:0]   lidx, ridx, count_ext;

  assign cnt_pos   = count_q[AW-1:0];
  assign cnt_m1    = cnt_pos - AW'(1);
  assign bidx_m1   = bidx_q - AW'(1);
  assign lidx      = {1'b0, pos_q, 1'b1};
  assign ridx      = lidx + LW'(1);
  assign count_ext = LW'(count_q);
  assign rdata     = entry_t'(rdata_raw);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    bidx_d  = bidx_q;
    item_d  = item_q;
    best_d  = best_q;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = item_q;
    re      = 1'b0;
    raddr   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.push) begin
          item_d  = req_i.entry;
          pos_d   = cnt_pos;
          count_d = count_q + CW'(1);
          if (count_q == '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = req_i.entry;
          end else begin
            re      = 1'b1;
            raddr   = AW'(cnt_m1 >> 1);
            bidx_d  = AW'(cnt_m1 >> 1);
            state_d = S_UP;
          end
        end else if (req_i.pop) begin
          re      = 1'b1;
          raddr   = '0;
          count_d = count_q - CW'(1);
          state_d = S_ROOT;
        end
      end
      S_UP: begin
        // bidx_q holds the parent whose data just arrived
        if (entry_before(item_q, rdata)) begin
          we    = 1'b1;
          waddr = pos_q;
          wdata = rdata;
          pos_d = bidx_q;
          if (bidx_q == '0) begin
            state_d = S_WR;
          end else begin
            re     = 1'b1;
            raddr  = AW'(bidx_m1 >> 1);
            bidx_d = AW'(bidx_m1 >> 1);
          end
        end else begin
          we      = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WR: begin
        we      = 1'b1;
        state_d = S_IDLE;
      end
      S_ROOT: begin
        if (count_q == '0) begin
          state_d = S_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = cnt_pos;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        item_d  = rdata;
        pos_d   = '0;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (lidx >= count_ext) begin
          we      = 1'b1;
          state_d = S_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = lidx[AW-1:0];
          state_d = S_LEFT;
        end
      end
      S_LEFT: begin
        best_d = rdata;
        bidx_d = lidx[AW-1:0];
        if (ridx < count_ext) begin
          re      = 1'b1;
          raddr   = ridx[AW-1:0];
          state_d = S_RIGHT;
        end else begin
          state_d = S_CMP;
        end
      end
      S_RIGHT: begin
        if (entry_before(rdata, best_q)) begin
          best_d = rdata;
          bidx_d = ridx[AW-1:0];
        end
        state_d = S_CMP;
      end
      S_CMP: begin
        if (entry_before(best_q, item_q)) begin
          we      = 1'b1;
          wdata   = best_q;
          pos_d   = bidx_q;
          state_d = S_CHK;
        end else begin
          we      = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    bidx_q <= bidx_d;
    item_q <= item_d;
    best_q <= best_d;
  end

  mhjd_ram #(
    .WIDTH(EntryBits),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign rsp_o.busy       = (state_q != S_IDLE);
  assign rsp_o.full       = (count_q == CW'(DEPTH));
  assign rsp_o.empty      = (count_q == '0);
  assign rsp_o.root_valid = (state_q == S_ROOT);
  assign rsp_o.root       = rdata;

endmodule

// ===== rtl/mhjd_checker.sv =====
// ----------------------------------------------------------------------------
// mhjd_checker
// Port-level checks of the job dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_heap_job_dispatcher_defines.svh"

module mhjd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mhjd_pkg::out_item_t out_data_o
);
  import mhjd_pkg::*;

  `MHJD_ASSERT_RST(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")

  `MHJD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled output transaction changed")

  `MHJD_ASSERT(a_drop_zero, clk_i, rst_ni, out_valid_o && (out_data_o.kind == KindDrop) |-> (out_data_o.dispatch_time == '0) && (out_data_o.finish_time == '0) && (out_data_o.wait_time == '0), "drop result with nonzero times")

  `MHJD_ASSERT(a_wait_calc, clk_i, rst_ni, out_valid_o && (out_data_o.kind == KindDispatch) |-> out_data_o.wait_time == TimeBits'(out_data_o.dispatch_time - out_data_o.out_start), "wait time mismatch")

  `MHJD_ASSERT(a_hs_known, clk_i, rst_ni, !$isunknown({in_ready_o, out_valid_o}), "handshake output unknown")

endmodule

bind min_heap_job_dispatcher mhjd_checker u_mhjd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
